FILE: design/oat_pkg.sv
// Shared codes, payload types, controller states and control structs for the table engine.
package oat_pkg;

    localparam logic [3:0] REQ_PUSH_BACK  = 4'd0;
    localparam logic [3:0] REQ_PUSH_FRONT = 4'd1;
    localparam logic [3:0] REQ_POP_BACK   = 4'd2;
    localparam logic [3:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [3:0] REQ_INSERT     = 4'd4;
    localparam logic [3:0] REQ_ERASE      = 4'd5;
    localparam logic [3:0] REQ_REPLACE    = 4'd6;
    localparam logic [3:0] REQ_GET        = 4'd7;
    localparam logic [3:0] REQ_SEARCH     = 4'd8;
    localparam logic [3:0] REQ_CLEAR      = 4'd9;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [6:0]  position;
        logic [5:0]  end_position;
        logic [31:0] item_value;
        logic [31:0] new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        found;
        logic [5:0]  found_index;
        logic [6:0]  element_total;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_FLUSH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic walk_en;
        logic walk_last;
        logic out_free;
    } sts_t;

endpackage

FILE: design/oat_if.sv
// Valid/ready channel interfaces for requests and responses.
interface oat_req_if;
    import oat_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface oat_rsp_if;
    import oat_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/oat_ctrl.sv
// Controller state machine that sequences decode, memory walk and result hand-over.
module oat_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  oat_pkg::sts_t sts,
    output oat_pkg::cmd_t cmd
);
    import oat_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = sts.walk_en ? S_WALK : S_FINISH;
            end
            S_WALK:
            begin
                if (sts.walk_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            S_WALK:
            begin
                cmd.issue = 1'b1;
            end
            S_FLUSH:
            begin
                cmd = '0;
            end
            S_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/oat_datapath.sv
// Datapath: request registers, element memory with its walk pipeline, count and result register.
module oat_datapath #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  oat_pkg::cmd_t cmd,
    output oat_pkg::sts_t sts,
    input  oat_pkg::req_t in_payload,
    output logic          out_valid,
    input  logic          out_ready,
    output oat_pkg::rsp_t out_payload
);
    import oat_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    // Request held for the whole transaction.
    logic [3:0]            req_type_reg;
    logic [6:0]            pos_reg;
    logic [5:0]            endp_reg;
    logic [ELEM_WIDTH-1:0] item_reg;
    logic [ELEM_WIDTH-1:0] new_reg;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_new_reg;
    logic [1:0]            status_reg;
    logic                  fw_en_reg;
    logic [AW-1:0]         fw_addr_reg;

    logic [AW-1:0]         rd_addr_reg;
    logic [AW-1:0]         last_reg;
    logic                  down_reg;
    logic                  first_pending_reg;
    logic                  s1_valid_reg;
    logic                  s1_first_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [ELEM_WIDTH-1:0] rdata_reg;

    logic [ELEM_WIDTH-1:0] rd_reg;
    logic                  found_reg;
    logic [AW-1:0]         idx_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    rsp_t                  out_reg;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    logic [63:0]           item_wide;
    logic [63:0]           new_wide;
    logic [63:0]           rd_wide;
    logic [63:0]           idx_wide;
    logic [63:0]           cnt_wide;

    // Decode results.
    logic [CMPW-1:0]       pos_x;
    logic [CMPW-1:0]       endp_x;
    logic [CMPW-1:0]       cnt_x;
    logic                  is_full;
    logic                  is_empty;
    logic [CW-1:0]         cnt_m1;
    logic [AW-1:0]         cnt_m1_a;
    logic [AW-1:0]         pos_a;
    logic [AW-1:0]         endp_a;
    logic [1:0]            dec_status;
    logic                  dec_walk;
    logic [AW-1:0]         dec_start;
    logic [AW-1:0]         dec_last;
    logic                  dec_down;
    logic                  dec_fw_en;
    logic [AW-1:0]         dec_fw_addr;
    logic [CW-1:0]         dec_count;

    // Memory write port.
    logic                  match;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;

    assign item_wide = 64'(in_payload.item_value);
    assign new_wide  = 64'(in_payload.new_value);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= in_payload.req_type;
            pos_reg      <= in_payload.position;
            endp_reg     <= in_payload.end_position;
            item_reg     <= item_wide[ELEM_WIDTH-1:0];
            new_reg      <= new_wide[ELEM_WIDTH-1:0];
        end
    end

    assign pos_x    = CMPW'(pos_reg);
    assign endp_x   = CMPW'(endp_reg);
    assign cnt_x    = CMPW'(count_reg);
    assign is_full  = cnt_x >= CMPW'(DEPTH);
    assign is_empty = (count_reg == '0);
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m1_a = cnt_m1[AW-1:0];
    assign pos_a    = pos_x[AW-1:0];
    assign endp_a   = endp_x[AW-1:0];

    always_comb
    begin
        dec_status  = STATUS_OK;
        dec_walk    = 1'b0;
        dec_start   = '0;
        dec_last    = '0;
        dec_down    = 1'b0;
        dec_fw_en   = 1'b0;
        dec_fw_addr = '0;
        dec_count   = count_reg;
        unique case (req_type_reg)
            REQ_PUSH_BACK:
            begin
                if (is_full)
                begin
                    dec_status = STATUS_FULL;
                end
                else
                begin
                    dec_fw_en   = 1'b1;
                    dec_fw_addr = count_reg[AW-1:0];
                    dec_count   = count_reg + CW'(1);
                end
            end
            REQ_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    dec_status = STATUS_FULL;
                end
                else
                begin
                    dec_fw_en = 1'b1;
                    dec_count = count_reg + CW'(1);
                    dec_walk  = !is_empty;
                    dec_start = cnt_m1_a;
                    dec_down  = 1'b1;
                end
            end
            REQ_POP_BACK:
            begin
                if (is_empty)
                begin
                    dec_status = STATUS_EMPTY;
                end
                else
                begin
                    dec_walk  = 1'b1;
                    dec_start = cnt_m1_a;
                    dec_last  = cnt_m1_a;
                    dec_count = cnt_m1;
                end
            end
            REQ_POP_FRONT:
            begin
                if (is_empty)
                begin
                    dec_status = STATUS_EMPTY;
                end
                else
                begin
                    dec_walk  = 1'b1;
                    dec_last  = cnt_m1_a;
                    dec_count = cnt_m1;
                end
            end
            REQ_INSERT:
            begin
                if (pos_x > cnt_x)
                begin
                    dec_status = STATUS_RANGE;
                end
                else if (is_full)
                begin
                    dec_status = STATUS_FULL;
                end
                else
                begin
                    dec_fw_en   = 1'b1;
                    dec_fw_addr = pos_a;
                    dec_count   = count_reg + CW'(1);
                    dec_walk    = (pos_x < cnt_x);
                    dec_start   = cnt_m1_a;
                    dec_last    = pos_a;
                    dec_down    = 1'b1;
                end
            end
            REQ_ERASE:
            begin
                if (pos_x >= cnt_x)
                begin
                    dec_status = STATUS_RANGE;
                end
                else
                begin
                    dec_walk  = 1'b1;
                    dec_start = pos_a;
                    dec_last  = cnt_m1_a;
                    dec_count = cnt_m1;
                end
            end
            REQ_REPLACE:
            begin
                if (pos_x >= cnt_x || endp_x >= cnt_x || pos_x > endp_x)
                begin
                    dec_status = STATUS_RANGE;
                end
                else
                begin
                    dec_walk  = 1'b1;
                    dec_start = pos_a;
                    dec_last  = endp_a;
                end
            end
            REQ_GET:
            begin
                if (pos_x >= cnt_x)
                begin
                    dec_status = STATUS_RANGE;
                end
                else
                begin
                    dec_walk  = 1'b1;
                    dec_start = pos_a;
                    dec_last  = pos_a;
                end
            end
            REQ_SEARCH:
            begin
                dec_walk = !is_empty;
                dec_last = cnt_m1_a;
            end
            REQ_CLEAR:
            begin
                dec_count = '0;
            end
            default:
            begin
                dec_count = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            status_reg    <= dec_status;
            fw_en_reg     <= dec_fw_en;
            fw_addr_reg   <= dec_fw_addr;
            count_new_reg <= dec_count;
            last_reg      <= dec_last;
            down_reg      <= dec_down;
        end
    end

    // Walk address and the stage that holds the data read in the previous cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            rd_addr_reg <= dec_start;
        end
        else if (cmd.issue)
        begin
            rd_addr_reg <= down_reg ? rd_addr_reg - AW'(1) : rd_addr_reg + AW'(1);
        end
        if (cmd.issue)
        begin
            s1_addr_reg  <= rd_addr_reg;
            s1_first_reg <= first_pending_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            first_pending_reg <= 1'b0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            if (cmd.decode)
            begin
                first_pending_reg <= 1'b1;
            end
            else if (cmd.issue)
            begin
                first_pending_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                count_reg <= count_new_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign match = (rdata_reg == item_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = rdata_reg;
        if (s1_valid_reg)
        begin
            case (req_type_reg) inside
                REQ_PUSH_FRONT, REQ_INSERT:
                begin
                    wr_en   = 1'b1;
                    wr_addr = s1_addr_reg + AW'(1);
                end
                REQ_POP_FRONT, REQ_ERASE:
                begin
                    // The first entry read is the one being dropped.
                    wr_en   = !s1_first_reg;
                    wr_addr = s1_addr_reg - AW'(1);
                end
                REQ_REPLACE:
                begin
                    wr_en   = match;
                    wr_data = new_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        if (cmd.finish && fw_en_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = fw_addr_reg;
            wr_data = item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg    <= '0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (s1_valid_reg)
        begin
            case (req_type_reg) inside
                REQ_POP_BACK, REQ_POP_FRONT, REQ_GET:
                begin
                    if (s1_first_reg)
                    begin
                        rd_reg <= rdata_reg;
                    end
                end
                REQ_SEARCH:
                begin
                    if (match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        idx_reg   <= s1_addr_reg;
                    end
                end
                default:
                begin
                    rd_reg <= rd_reg;
                end
            endcase
        end
    end

    assign rd_wide  = 64'(rd_reg);
    assign idx_wide = 64'(idx_reg);
    assign cnt_wide = 64'(count_new_reg);

    assign out_valid_next = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.status        <= status_reg;
            out_reg.read_value    <= rd_wide[31:0];
            out_reg.found         <= found_reg;
            out_reg.found_index   <= idx_wide[5:0];
            out_reg.element_total <= cnt_wide[6:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_payload   = out_reg;
    assign sts.walk_en   = dec_walk;
    assign sts.walk_last = (rd_addr_reg == last_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule

FILE: design/ordered_array_table_engine_top.sv
// Top level of the ordered table engine: controller, datapath and checks.
//
//  Channel | Direction | Payload                                         | Handshake
//  req     | in        | req_type, position, end_position, item, new     | valid/ready
//  rsp     | out       | status, read_value, found, found_index, total   | valid/ready
//
// Push back, pop with an empty table, clear and refused requests skip the memory walk.
// A request that walks the memory reads N entries, N being the entries walked (up to
// DEPTH): the single read port of the element memory moves one entry per cycle.
// Reset clears the element count and the control state, not the memory; memory contents are never read before written.
// A new transaction is accepted while a result waits; the result hand-over holds until
// the response register is free.
module ordered_array_table_engine_top #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    oat_req_if.sink    req,
    oat_rsp_if.source  rsp
);
    import oat_pkg::*;

    cmd_t cmd;
    sts_t sts;

    oat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oat_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_payload  (req.payload),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_payload (rsp.payload)
    );

    // A result is only written into a free response register.
    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp.valid || rsp.ready))
        else $error("result written over a pending response");

    // The engine is busy for the cycle after a transaction is accepted.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while a transaction is in progress");

    // A refused request returns no data and no search hit.
    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.status != STATUS_OK) |->
        (rsp.payload.read_value == 32'd0 && !rsp.payload.found))
        else $error("refused request returned data");

    // The reported count never exceeds the table size.
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (32'(rsp.payload.element_total) <= DEPTH))
        else $error("element total above table depth");

endmodule
